### sv/vnc_pkg.sv
`timescale 1ns / 1ps

package vnc_pkg;

  localparam int MAX_X = 64;
  localparam int MAX_Y = 64;
  localparam int MAX_Z = 4096;
  localparam int HALO  = 2;

  localparam int X_W    = $clog2(MAX_X);
  localparam int Y_W    = $clog2(MAX_Y);
  localparam int Z_W    = $clog2(MAX_Z);
  localparam int SX_W   = 7;
  localparam int SY_W   = 7;
  localparam int SZ_W   = 13;
  localparam int CODE_W = 11;
  localparam int DIG_W  = 3;
  localparam int SUM_W  = 10;
  localparam int CFG_A_W = 2;
  localparam int CFG_D_W = 13;

  localparam logic [CFG_A_W-1:0] REG_SIZE_X = 2'd0;
  localparam logic [CFG_A_W-1:0] REG_SIZE_Y = 2'd1;
  localparam logic [CFG_A_W-1:0] REG_SIZE_Z = 2'd2;

  localparam logic [SZ_W-1:0] SIZE_MIN = 13'd5;

  typedef logic [DIG_W-1:0] digit_t;

  typedef struct packed {
    logic ll;
    logic l;
    logic r;
    logic rr;
  } axis_t;

  function automatic digit_t classify(input axis_t a);
    digit_t d;
    if (a.l && a.r) begin
      d = 3'd1;
    end else if (a.l && !a.r && a.rr) begin
      d = 3'd2;
    end else if (!a.l && a.ll && a.r) begin
      d = 3'd3;
    end else if (a.l && !a.r) begin
      d = 3'd4;
    end else if (!a.l && !a.ll && a.r) begin
      d = 3'd5;
    end else begin
      d = 3'd6;
    end
    return d;
  endfunction

  function automatic logic [SZ_W-1:0] clamp_size(input logic [SZ_W-1:0] v,
                                                 input logic [SZ_W-1:0] hi);
    logic [SZ_W-1:0] r;
    if (v < SIZE_MIN) begin
      r = SIZE_MIN;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

### sv/vnc_code.sv
`timescale 1ns / 1ps

module vnc_code import vnc_pkg::*; (
  input  logic                     solid,
  input  digit_t                   cx,
  input  digit_t                   cy,
  input  axis_t                    zax,
  output logic signed [CODE_W-1:0] code
);

  digit_t           cz;
  logic [SUM_W-1:0] sum;

  always_comb begin
    cz  = classify(zax);
    sum = SUM_W'(cx) * SUM_W'(100) + SUM_W'(cy) * SUM_W'(10) + SUM_W'(cz);
    if (solid) begin
      code = '1;
    end else begin
      code = {1'b0, sum};
    end
  end

endmodule

### sv/voxel_neighborhood_classifier_top.sv
`timescale 1ns / 1ps
// Neighborhood classifier for a padded solid/fluid voxel volume.
// The input channel (in_valid, in_ready, in_voxel_solid) takes one voxel per
// item in raster order, x fastest, then y, then z. The result channel carries
// one item per interior voxel: its code (-1 solid, else 100*cx+10*cy+cz),
// its coordinates and a flag on the last interior voxel of the volume.
// A result leaves in the cycle after the input item at the same x and y two
// planes further on is accepted. One item is accepted per cycle unless the
// output stalls; the rate is set by the single read port of each on-chip store,
// which is read one position ahead of the input so its data is ready in time.
// The result sits in an output register; a new item is accepted in any cycle
// in which that register is empty or being taken, so a stalled receiver
// stalls the input only while a result is held.
// Reset empties the output register, sets every size to 64 and restarts the
// volume at position zero. A size write clamps the value to its legal range
// and also restarts the volume. The stores need no clearing after reset.
module voxel_neighborhood_classifier_top import vnc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_A_W-1:0]       cfg_addr,
  input  logic [CFG_D_W-1:0]       cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_voxel_solid,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [CODE_W-1:0] out_neighborhood_code,
  output logic [X_W-1:0]           out_x,
  output logic [Y_W-1:0]           out_y,
  output logic [Z_W-1:0]           out_z,
  output logic                     out_last_result
);

  logic [SX_W-1:0] size_x_r, size_x_nxt;
  logic [SY_W-1:0] size_y_r, size_y_nxt;
  logic [SZ_W-1:0] size_z_r, size_z_nxt;
  logic [X_W-1:0]  pos_x_r, pos_x_nxt, rd_x;
  logic [Y_W-1:0]  pos_y_r, pos_y_nxt, rd_y;
  logic [Z_W-1:0]  pos_z_r, pos_z_nxt, rd_z;
  logic [3:0]      win_r;

  logic [3:0]   col_mem [MAX_X*MAX_Y];
  logic [3:0]   line_mem [MAX_X];
  digit_t       cy_mem [2*MAX_X*MAX_Y];
  digit_t       cx_mem [2*MAX_X*MAX_Y];
  logic [3:0]   col_q, line_q;
  digit_t       cy_q, cx_q;

  logic                     accept, cfg_hit, emit, last;
  logic                     out_valid_r;
  logic signed [CODE_W-1:0] code_r, code;
  logic [X_W-1:0]           ox_r;
  logic [Y_W-1:0]           oy_r;
  logic [Z_W-1:0]           oz_r;
  logic                     olast_r;
  axis_t                    xax, yax, zax;
  digit_t                   cx_new, cy_new;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign cfg_hit  = cfg_we && (cfg_addr == REG_SIZE_X || cfg_addr == REG_SIZE_Y ||
                               cfg_addr == REG_SIZE_Z);

  always_comb begin
    size_x_nxt = size_x_r;
    size_y_nxt = size_y_r;
    size_z_nxt = size_z_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_SIZE_X: size_x_nxt = SX_W'(clamp_size({6'd0, cfg_wdata[SX_W-1:0]},
                                                  SZ_W'(MAX_X)));
        REG_SIZE_Y: size_y_nxt = SY_W'(clamp_size({6'd0, cfg_wdata[SY_W-1:0]},
                                                  SZ_W'(MAX_Y)));
        REG_SIZE_Z: size_z_nxt = clamp_size(cfg_wdata, SZ_W'(MAX_Z));
        default: ;
      endcase
    end
  end

  always_comb begin
    pos_x_nxt = pos_x_r;
    pos_y_nxt = pos_y_r;
    pos_z_nxt = pos_z_r;
    if (cfg_hit) begin
      pos_x_nxt = '0;
      pos_y_nxt = '0;
      pos_z_nxt = '0;
    end else if (accept) begin
      if ({1'b0, pos_x_r} + 7'd1 < size_x_r) begin
        pos_x_nxt = pos_x_r + X_W'(1);
      end else begin
        pos_x_nxt = '0;
        if ({1'b0, pos_y_r} + 7'd1 < size_y_r) begin
          pos_y_nxt = pos_y_r + Y_W'(1);
        end else begin
          pos_y_nxt = '0;
          if ({1'b0, pos_z_r} + 13'd1 < size_z_r) begin
            pos_z_nxt = pos_z_r + Z_W'(1);
          end else begin
            pos_z_nxt = '0;
          end
        end
      end
    end
    rd_x = rst_n ? pos_x_nxt : '0;
    rd_y = rst_n ? pos_y_nxt : '0;
    rd_z = rst_n ? pos_z_nxt : '0;
  end

  // Each store is read at the next position so its data lines up with the item.
  always_ff @(posedge clk) begin
    col_q  <= col_mem[{rd_y, rd_x}];
    line_q <= line_mem[rd_x];
    cy_q   <= cy_mem[{rd_z[0], rd_y, rd_x}];
    cx_q   <= cx_mem[{rd_z[0], rd_y, rd_x}];
    if (accept) begin
      col_mem[{pos_y_r, pos_x_r}] <= {col_q[2:0], in_voxel_solid};
      line_mem[pos_x_r] <= {line_q[2:0], in_voxel_solid};
      if (pos_y_r >= Y_W'(2*HALO)) begin
        cy_mem[{pos_z_r[0], pos_y_r - Y_W'(HALO), pos_x_r}] <= cy_new;
      end
      if (pos_x_r >= X_W'(2*HALO)) begin
        cx_mem[{pos_z_r[0], pos_y_r, pos_x_r - X_W'(HALO)}] <= cx_new;
      end
    end
  end

  always_comb begin
    xax    = '{ll: win_r[3], l: win_r[2], r: win_r[0], rr: in_voxel_solid};
    yax    = '{ll: line_q[3], l: line_q[2], r: line_q[0], rr: in_voxel_solid};
    zax    = '{ll: col_q[3], l: col_q[2], r: col_q[0], rr: in_voxel_solid};
    cx_new = classify(xax);
    cy_new = classify(yax);
    emit   = pos_z_r >= Z_W'(2*HALO) && pos_x_r >= X_W'(HALO) &&
             {1'b0, pos_x_r} + 7'(HALO) < size_x_r && pos_y_r >= Y_W'(HALO) &&
             {1'b0, pos_y_r} + 7'(HALO) < size_y_r;
    last   = {1'b0, pos_x_r} + 7'(HALO + 1) == size_x_r &&
             {1'b0, pos_y_r} + 7'(HALO + 1) == size_y_r &&
             {1'b0, pos_z_r} + 13'd1 == size_z_r;
  end

  vnc_code u_code (
    .solid (col_q[1]),
    .cx    (cx_q),
    .cy    (cy_q),
    .zax   (zax),
    .code  (code)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r    <= SX_W'(64);
      size_y_r    <= SY_W'(64);
      size_z_r    <= SZ_W'(64);
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      pos_z_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      size_x_r <= size_x_nxt;
      size_y_r <= size_y_nxt;
      size_z_r <= size_z_nxt;
      pos_x_r  <= pos_x_nxt;
      pos_y_r  <= pos_y_nxt;
      pos_z_r  <= pos_z_nxt;
      if (accept) begin
        out_valid_r <= emit;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win_r <= {win_r[2:0], in_voxel_solid};
    end
    if (accept && emit) begin
      code_r  <= code;
      ox_r    <= pos_x_r;
      oy_r    <= pos_y_r;
      oz_r    <= pos_z_r - Z_W'(HALO);
      olast_r <= last;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_neighborhood_code = code_r;
  assign out_x                 = ox_r;
  assign out_y                 = oy_r;
  assign out_z                 = oz_r;
  assign out_last_result       = olast_r;

  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    accept && emit |=> out_valid_r)
    else $error("Interior item gave no result.");

  a_coord_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ox_r >= X_W'(HALO) && oy_r >= Y_W'(HALO) && oz_r >= Z_W'(HALO))
    else $error("Result coordinate lies in the border.");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> code_r == -11'sd1 || (code_r >= 11'sd111 && code_r <= 11'sd666))
    else $error("Result code out of range.");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, pos_x_r} < size_x_r && {1'b0, pos_y_r} < size_y_r &&
    {1'b0, pos_z_r} < size_z_r)
    else $error("Position outside the volume.");

endmodule
